### hw/rtl/slex_pkg.sv
// ----------------------------------------------------------------------------
// slex_pkg: shared types and constants of the SQL token lexer
// Beat types, token kinds, scanner modes, character codes and byte classes.
// ----------------------------------------------------------------------------
`default_nettype none

package slex_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int OUT_OFF_W       = 16;
   localparam int SLOTS           = 3;

   typedef enum logic [3:0] {
      KIND_IDENT  = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_STRING = 4'd2,
      KIND_LPAREN = 4'd3,
      KIND_RPAREN = 4'd4,
      KIND_DOT    = 4'd5,
      KIND_COMMA  = 4'd6,
      KIND_OTHER  = 4'd7,
      KIND_END    = 4'd8
   } tok_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_IDENT  = 4'd1,
      MODE_NUMBER = 4'd2,
      MODE_DOTP   = 4'd3,
      MODE_DASHP  = 4'd4,
      MODE_SLASHP = 4'd5,
      MODE_STR    = 4'd6,
      MODE_STRQ   = 4'd7,
      MODE_LINE   = 4'd8,
      MODE_BLOCK  = 4'd9,
      MODE_BSTAR  = 4'd10
   } lex_mode_type;

   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]           token_kind;
      logic [7:0]           single_char;
      logic [OUT_OFF_W-1:0] token_begin;
      logic [OUT_OFF_W-1:0] token_finish;
      logic                 run_last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]           kind;
      logic [7:0]           single_char;
      logic [OUT_OFF_W-1:0] token_begin;
      logic [OUT_OFF_W-1:0] token_finish;
   } tok_type;

   // all tokens caused by one input byte
   typedef struct packed {
      tok_type [SLOTS-1:0] slot;
      logic [1:0]          count;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic tok_kind_type single_kind(input logic [7:0] c);
      tok_kind_type k;
      case (c)
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         default:   k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/slex_front.sv
// ----------------------------------------------------------------------------
// slex_front: byte classifier and scanner state
// Takes one byte a beat, advances the scanner and forms the tokens it decides.
// ----------------------------------------------------------------------------
`default_nettype none

module slex_front #(
   parameter int OFFSET_BITS = slex_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire slex_pkg::req_type   req,
   output logic                     push,
   output slex_pkg::bundle_type     bundle
);

   slex_pkg::lex_mode_type mode_ff, mode_in;
   logic                   quote_ff, quote_in;
   logic                   has_dot_ff, has_dot_in;
   logic [OFFSET_BITS-1:0] origin_ff, origin_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   logic [7:0]             c;
   logic [7:0]             qc;
   logic [OFFSET_BITS-1:0] p;
   logic [OFFSET_BITS-1:0] e;
   logic                   rescan;
   logic [1:0]             n;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic slex_pkg::tok_type mk_tok(
      input slex_pkg::tok_kind_type k,
      input logic [7:0]             ch,
      input logic [OFFSET_BITS-1:0] b,
      input logic [OFFSET_BITS-1:0] f
   );
      slex_pkg::tok_type t;
      t.kind         = k;
      t.single_char  = ch;
      t.token_begin  = slex_pkg::OUT_OFF_W'(b);
      t.token_finish = slex_pkg::OUT_OFF_W'(f);
      return t;
   endfunction

   always_comb begin
      mode_in    = mode_ff;
      quote_in   = quote_ff;
      has_dot_in = has_dot_ff;
      origin_in  = origin_ff;
      pos_in     = pos_ff;
      bundle     = '0;
      n          = 2'd0;
      rescan     = 1'b0;
      c          = req.char_byte;
      p          = pos_ff;
      e          = sat_inc(pos_ff);
      qc         = quote_ff ? slex_pkg::CH_DQUOTE : slex_pkg::CH_SQUOTE;

      case (mode_ff)
         slex_pkg::MODE_IDENT: begin
            if (!(slex_pkg::is_alpha(c) || slex_pkg::is_digit(c) ||
                  c == slex_pkg::CH_UNDER)) begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_IDENT, 8'd0, origin_ff, p);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_NUMBER: begin
            if (slex_pkg::is_digit(c)) begin
               has_dot_in = has_dot_ff;
            end else if (c == slex_pkg::CH_DOT && !has_dot_ff) begin
               has_dot_in = 1'b1;
            end else begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_NUMBER, 8'd0, origin_ff, p);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_DOTP: begin
            if (slex_pkg::is_digit(c)) begin
               mode_in    = slex_pkg::MODE_NUMBER;
               has_dot_in = 1'b1;
            end else begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_DOT, slex_pkg::CH_DOT,
                                       origin_ff, sat_inc(origin_ff));
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_DASHP: begin
            if (c == slex_pkg::CH_DASH) begin
               mode_in = slex_pkg::MODE_LINE;
            end else begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_OTHER, slex_pkg::CH_DASH,
                                       origin_ff, sat_inc(origin_ff));
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_SLASHP: begin
            if (c == slex_pkg::CH_STAR) begin
               mode_in = slex_pkg::MODE_BLOCK;
            end else begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_OTHER, slex_pkg::CH_SLASH,
                                       origin_ff, sat_inc(origin_ff));
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_STR: begin
            if (c == qc) mode_in = slex_pkg::MODE_STRQ;
         end
         slex_pkg::MODE_STRQ: begin
            // doubled quote: stay inside the string
            if (c == qc) begin
               mode_in = slex_pkg::MODE_STR;
            end else begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_STRING, 8'd0, origin_ff, p);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         slex_pkg::MODE_LINE: begin
            if (c == slex_pkg::CH_NEWLINE) mode_in = slex_pkg::MODE_IDLE;
         end
         slex_pkg::MODE_BLOCK: begin
            if (c == slex_pkg::CH_STAR) mode_in = slex_pkg::MODE_BSTAR;
         end
         slex_pkg::MODE_BSTAR: begin
            if (c == slex_pkg::CH_SLASH) begin
               mode_in = slex_pkg::MODE_IDLE;
            end else if (c != slex_pkg::CH_STAR) begin
               mode_in = slex_pkg::MODE_BLOCK;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // scan the byte as the start of a new token
      if (rescan) begin
         mode_in   = slex_pkg::MODE_IDLE;
         origin_in = p;
         if (slex_pkg::is_space(c)) begin
            mode_in = slex_pkg::MODE_IDLE;
         end else if (c == slex_pkg::CH_SQUOTE || c == slex_pkg::CH_DQUOTE) begin
            quote_in = (c == slex_pkg::CH_DQUOTE);
            mode_in  = slex_pkg::MODE_STR;
         end else if (c == slex_pkg::CH_DASH) begin
            mode_in = slex_pkg::MODE_DASHP;
         end else if (c == slex_pkg::CH_SLASH) begin
            mode_in = slex_pkg::MODE_SLASHP;
         end else if (slex_pkg::is_alpha(c) || c == slex_pkg::CH_UNDER) begin
            mode_in = slex_pkg::MODE_IDENT;
         end else if (slex_pkg::is_digit(c)) begin
            mode_in    = slex_pkg::MODE_NUMBER;
            has_dot_in = 1'b0;
         end else if (c == slex_pkg::CH_DOT) begin
            mode_in = slex_pkg::MODE_DOTP;
         end else begin
            bundle.slot[n] = mk_tok(slex_pkg::single_kind(c), c, p, sat_inc(p));
            n = n + 2'd1;
         end
      end

      // flush the pending token, add the end marker, restart at offset zero
      if (req.final_byte) begin
         case (mode_in)
            slex_pkg::MODE_IDENT: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_IDENT, 8'd0, origin_in, e);
               n = n + 2'd1;
            end
            slex_pkg::MODE_NUMBER: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_NUMBER, 8'd0, origin_in, e);
               n = n + 2'd1;
            end
            slex_pkg::MODE_DOTP: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_DOT, slex_pkg::CH_DOT,
                                       origin_in, sat_inc(origin_in));
               n = n + 2'd1;
            end
            slex_pkg::MODE_DASHP: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_OTHER, slex_pkg::CH_DASH,
                                       origin_in, sat_inc(origin_in));
               n = n + 2'd1;
            end
            slex_pkg::MODE_SLASHP: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_OTHER, slex_pkg::CH_SLASH,
                                       origin_in, sat_inc(origin_in));
               n = n + 2'd1;
            end
            slex_pkg::MODE_STR, slex_pkg::MODE_STRQ: begin
               bundle.slot[n] = mk_tok(slex_pkg::KIND_STRING, 8'd0, origin_in, e);
               n = n + 2'd1;
            end
            default: begin
               n = n;
            end
         endcase
         bundle.slot[n] = mk_tok(slex_pkg::KIND_END, 8'd0, e, e);
         n = n + 2'd1;
         mode_in    = slex_pkg::MODE_IDLE;
         quote_in   = 1'b0;
         has_dot_in = 1'b0;
         origin_in  = '0;
         pos_in     = '0;
      end else begin
         pos_in = e;
      end

      bundle.count = n;
   end

   assign push = take && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= slex_pkg::MODE_IDLE;
         quote_ff   <= 1'b0;
         has_dot_ff <= 1'b0;
         origin_ff  <= '0;
         pos_ff     <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         quote_ff   <= quote_in;
         has_dot_ff <= has_dot_in;
         origin_ff  <= origin_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/slex_queue.sv
// ----------------------------------------------------------------------------
// slex_queue: two-entry token bundle queue
// Decouples the byte scanner from the token serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module slex_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire slex_pkg::bundle_type wr_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output slex_pkg::bundle_type      head
);

   slex_pkg::bundle_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/slex_back.sv
// ----------------------------------------------------------------------------
// slex_back: token serializer and output register
// Walks the head bundle one token a beat and holds the beat under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module slex_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire slex_pkg::bundle_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output slex_pkg::rsp_type         rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   slex_pkg::rsp_type rsp_ff, rsp_in;
   logic [1:0]        idx_ff, idx_in;
   logic              load;
   logic              last;
   slex_pkg::tok_type cur;

   always_comb begin
      load         = head_valid && (!rsp_valid_ff || !rsp_stall);
      cur          = head.slot[idx_ff];
      last         = (idx_ff == head.count - 2'd1);
      pop          = load && last;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.token_kind     = cur.kind;
         rsp_in.single_char    = cur.single_char;
         rsp_in.token_begin    = cur.token_begin;
         rsp_in.token_finish   = cur.token_finish;
         rsp_in.run_last       = last;
         idx_in                = last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/sql_token_lexer.sv
// ----------------------------------------------------------------------------
// sql_token_lexer: byte-serial SQL tokenizer
// Scans SQL text a byte a beat and returns tokens with kind and offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte a beat, final_byte set on the last byte of
//   a text. The next byte after a final byte starts a new text at offset 0.
//   rsp channel: one token a beat; run_last marks the last token caused by
//   a given byte. Bytes that decide no token produce no beat.
//   A token reaches rsp through the bundle queue entry and then the output
//   register. Throughput: one byte per cycle while rsp is not stalled and
//   each byte yields at most one token; a byte that yields several tokens
//   holds the serializer for one token a beat, so the output register's one
//   token per cycle sets the sustained rate.
//   The two-entry bundle queue between scanner and serializer absorbs short
//   bursts; req_stall rises only when that queue is full.
//   Under rsp_stall the current beat holds, the queue fills and then req
//   stalls. Reset (synchronous) empties the queue and output register and
//   returns the scanner to idle at offset zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_lexer #(
   parameter int OFFSET_BITS = slex_pkg::OFFSET_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire slex_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output slex_pkg::rsp_type      rsp_data
);

   logic                 take;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_not_empty;
   slex_pkg::bundle_type wr_bundle;
   slex_pkg::bundle_type head;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   slex_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_data),
      .push   (push),
      .bundle (wr_bundle)
   );

   slex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   (wr_bundle),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   slex_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/slex_checker.sv
// ----------------------------------------------------------------------------
// slex_checker: port-level checks of the SQL token lexer
// Watches the top level's channels and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module slex_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire slex_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire slex_pkg::rsp_type rsp_data
);

   logic wide_kind;
   assign wide_kind = (rsp_data.token_kind == slex_pkg::KIND_IDENT)  ||
                      (rsp_data.token_kind == slex_pkg::KIND_NUMBER) ||
                      (rsp_data.token_kind == slex_pkg::KIND_STRING) ||
                      (rsp_data.token_kind == slex_pkg::KIND_END);

   // a stalled req beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req beat changed under stall");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == slex_pkg::KIND_END |->
         rsp_data.run_last && rsp_data.token_begin == rsp_data.token_finish)
      else $error("end marker malformed");

   a_wide_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && wide_kind |-> rsp_data.single_char == 8'd0)
      else $error("multi-byte token carries a character");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind sql_token_lexer slex_checker u_slex_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
